// File: rtl/tglc_pkg.sv
// types and constants of the two generation lookup cache
// no dependencies; imported by the interface users and the top level

package tglc_pkg;

  localparam int unsigned AddrW     = 64;
  localparam int unsigned FillW     = 32;
  localparam int unsigned EvictCntW = 7;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_EVICT  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] addr;
    logic [FillW-1:0] fill_value;
  } in_item_t;

  typedef struct packed {
    logic [FillW-1:0]     value;
    logic                 hit;
    logic                 table_full;
    logic [EvictCntW-1:0] evicted_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT,
    ST_OUT
  } state_e;

endpackage

// File: rtl/tglc_stream_if.sv
// valid/ready stream channel carrying one payload per transaction
// payload type set by the instantiating side; no other dependencies

interface tglc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/two_generation_lookup_cache.sv
// two generation lookup cache: in_i takes lookup and evict transactions,
// out_o returns one result transaction for each of them.
// entries live in a single memory {valid, generation, key, data} with one
// write port and one registered read port.
// a lookup walks every entry once, noting the first matching valid entry and
// the lowest free one, then writes the hit entry back into the current
// generation or stores the fill value in the free entry. an evict walks every
// entry, clearing previous generation entries as it goes, then flips the
// current generation and reports the count.
// an item is walked through the memory's read port (scan, last), then
// committed, then loaded into the output register; in_i.ready is high only
// in idle, so the next item is accepted after that. reset: a clearing pass
// writes every entry invalid, with in_i.ready low. when the receiver stalls,
// the result waits in the output register; the next item is accepted and
// walked meanwhile, and its result waits until the output register is free.
// depends on tglc_pkg and tglc_stream_if

module two_generation_lookup_cache
  import tglc_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tglc_stream_if.sink          in_i,
  tglc_stream_if.source        out_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = (VALUE_WIDTH < FillW) ? VALUE_WIDTH : FillW;

  typedef struct packed {
    logic             valid;
    logic             gen;
    logic [AddrW-1:0] key;
    logic [DW-1:0]    data;
  } entry_t;

  state_e state_q, state_d;

  logic [IW-1:0]    scan_idx_q, scan_idx_d;
  logic [IW-1:0]    proc_idx_q;
  logic             rd_pend_q;
  entry_t           rdata_q;
  logic             kind_q;
  logic [AddrW-1:0] addr_q;
  logic [DW-1:0]    fill_q;
  logic             cur_gen_q, cur_gen_d;
  logic             found_q, found_d;
  logic [IW-1:0]    hit_idx_q, hit_idx_d;
  logic [DW-1:0]    hit_data_q, hit_data_d;
  logic             free_q, free_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic [CW-1:0]    drop_cnt_q, drop_cnt_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  entry_t           mem_q [CAPACITY];
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  entry_t           mem_wdata;

  logic             accept;
  logic             last_idx;
  logic             out_load;
  logic             ent_prev;
  logic [CW+6:0]    drop_ext;
  logic [EvictCntW-1:0] evict_sat;

  assign accept   = in_i.valid && in_i.ready;
  assign last_idx = (scan_idx_q == IW'(CAPACITY - 1));
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign ent_prev = rdata_q.valid && (rdata_q.gen != cur_gen_q);
  assign drop_ext = {7'd0, drop_cnt_q};
  assign evict_sat = (drop_ext > (CW + 7)'(127)) ? EvictCntW'(127) : drop_ext[6:0];

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (last_idx) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (last_idx) state_d = ST_LAST;
      ST_LAST:   state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // scan bookkeeping and memory write port
  always_comb begin
    scan_idx_d = scan_idx_q;
    cur_gen_d  = cur_gen_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_data_d = hit_data_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    drop_cnt_d = drop_cnt_q;
    mem_we     = 1'b0;
    mem_waddr  = scan_idx_q;
    mem_wdata  = '0;

    if (rd_pend_q) begin
      if (kind_q == KIND_EVICT) begin
        if (ent_prev) begin
          mem_we          = 1'b1;
          mem_waddr       = proc_idx_q;
          mem_wdata       = rdata_q;
          mem_wdata.valid = 1'b0;
          drop_cnt_d      = drop_cnt_q + CW'(1);
        end
      end else if (rdata_q.valid) begin
        if (!found_q && (rdata_q.key == addr_q)) begin
          found_d    = 1'b1;
          hit_idx_d  = proc_idx_q;
          hit_data_d = rdata_q.data;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = proc_idx_q;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = scan_idx_q;
        mem_wdata  = '0;
        scan_idx_d = scan_idx_q + IW'(1);
      end
      ST_IDLE: begin
        scan_idx_d = '0;
        found_d    = 1'b0;
        free_d     = 1'b0;
        drop_cnt_d = '0;
      end
      ST_SCAN: begin
        if (!last_idx) scan_idx_d = scan_idx_q + IW'(1);
      end
      ST_COMMIT: begin
        if (kind_q == KIND_EVICT) begin
          cur_gen_d = ~cur_gen_q;
        end else if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = hit_idx_q;
          mem_wdata = '{valid: 1'b1, gen: cur_gen_q, key: addr_q, data: hit_data_q};
        end else if (free_q) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_q;
          mem_wdata = '{valid: 1'b1, gen: cur_gen_q, key: addr_q, data: fill_q};
        end
      end
      ST_LAST, ST_OUT: ;
      default: ;
    endcase
  end

  // result and output register
  always_comb begin
    out_d = out_q;
    if (kind_q == KIND_EVICT) begin
      out_d = '{value: '0, hit: 1'b0, table_full: 1'b0, evicted_count: evict_sat};
    end else if (found_q) begin
      out_d = '{value: FillW'(hit_data_q), hit: 1'b1, table_full: 1'b0,
                evicted_count: '0};
    end else begin
      out_d = '{value: FillW'(fill_q), hit: 1'b0, table_full: !free_q,
                evicted_count: '0};
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      cur_gen_q   <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      drop_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      rd_pend_q   <= (state_q == ST_SCAN);
      cur_gen_q   <= cur_gen_d;
      found_q     <= found_d;
      free_q      <= free_d;
      drop_cnt_q  <= drop_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= scan_idx_q;
    hit_idx_q  <= hit_idx_d;
    hit_data_q <= hit_data_d;
    free_idx_q <= free_idx_d;
    if (accept) begin
      kind_q <= in_i.payload.kind;
      addr_q <= in_i.payload.addr;
      fill_q <= in_i.payload.fill_value[DW-1:0];
    end
    if (out_load) out_q <= out_d;
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[scan_idx_q];
  end

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_OUT) |-> !mem_we)
    else $error("entry memory written outside a walk or commit");

  a_full_stores_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && kind_q == KIND_LOOKUP && !found_q && !free_q) |-> !mem_we)
    else $error("entry written although the table was full");

  a_drop_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_cnt_q <= CW'(CAPACITY))
    else $error("dropped entry count beyond capacity");

  a_gen_flip_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_gen_q != $past(cur_gen_q)) |-> ($past(state_q) == ST_COMMIT && kind_q == KIND_EVICT))
    else $error("current generation changed outside an evict commit");

  a_result_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result transaction raised without a finished walk");

endmodule

// File: verif/tglc_result_checker.sv
`timescale 1ns / 1ps
// result checker for the two generation lookup cache: watches both stream channels,
// predicts each result from the accepted requests and compares it field by field
// depends on tglc_pkg

module tglc_result_checker
  import tglc_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_payload_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_payload_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  localparam int unsigned CountMax = (1 << EvictCntW) - 1;

  logic [AddrW-1:0] line_addr [CAPACITY];
  logic [FillW-1:0] line_data [CAPACITY];
  logic             line_valid [CAPACITY];
  logic             line_gen [CAPACITY];
  logic             live_gen;

  out_item_t   awaited_results [$];
  out_item_t   oldest;
  int unsigned fail_count;

  function automatic out_item_t cache_access(in_item_t item);
    out_item_t        res;
    int unsigned      dropped;
    int               hit_idx;
    int               free_idx;
    logic [FillW-1:0] mask;
    res = '0;
    mask = (VALUE_WIDTH >= FillW) ? '1 : FillW'((64'd1 << VALUE_WIDTH) - 64'd1);
    if (item.kind == KIND_EVICT) begin
      dropped = 0;
      for (int i = 0; i < CAPACITY; i++) begin
        if (line_valid[i] && line_gen[i] != live_gen) begin
          line_valid[i] = 1'b0;
          dropped++;
        end
      end
      live_gen = ~live_gen;
      res.evicted_count = (dropped > CountMax) ? EvictCntW'(CountMax) : EvictCntW'(dropped);
    end else begin
      hit_idx  = -1;
      free_idx = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (line_valid[i]) begin
          if (hit_idx < 0 && line_addr[i] == item.addr) hit_idx = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit_idx >= 0) begin
        line_gen[hit_idx] = live_gen;
        res.value = line_data[hit_idx] & mask;
        res.hit   = 1'b1;
      end else if (free_idx >= 0) begin
        line_valid[free_idx] = 1'b1;
        line_gen[free_idx]   = live_gen;
        line_addr[free_idx]  = item.addr;
        line_data[free_idx]  = item.fill_value & mask;
        res.value = item.fill_value & mask;
      end else begin
        res.value      = item.fill_value & mask;
        res.table_full = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        line_valid[i] = 1'b0;
        line_gen[i]   = 1'b0;
      end
      live_gen = 1'b0;
      awaited_results.delete();
      fail_count = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transaction: value %h hit %b table_full %b evicted_count %0d",
                 out_payload_i.value, out_payload_i.hit, out_payload_i.table_full,
                 out_payload_i.evicted_count);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_payload_i.value !== oldest.value) begin
            $error("value: expected %h, actual %h", oldest.value, out_payload_i.value);
            fail_count++;
          end
          if (out_payload_i.hit !== oldest.hit) begin
            $error("hit: expected %b, actual %b", oldest.hit, out_payload_i.hit);
            fail_count++;
          end
          if (out_payload_i.table_full !== oldest.table_full) begin
            $error("table_full: expected %b, actual %b", oldest.table_full,
                   out_payload_i.table_full);
            fail_count++;
          end
          if (out_payload_i.evicted_count !== oldest.evicted_count) begin
            $error("evicted_count: expected %0d, actual %0d", oldest.evicted_count,
                   out_payload_i.evicted_count);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(cache_access(in_payload_i));
      end
      fail_count_o  <= fail_count;
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// File: verif/tb_two_generation_lookup_cache.sv
`timescale 1ns / 1ps
// testbench top for the two generation lookup cache: clock, reset, request stimulus,
// random stalls on both channels and the verdict; prediction lives in tglc_result_checker
// depends on tglc_pkg, tglc_stream_if, tglc_result_checker and the block itself

module tb_two_generation_lookup_cache
  import tglc_pkg::*;
;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PoolSize   = 128;
  localparam int unsigned CycleLimit = 1000000;

  logic clk_i;
  logic rst_ni;

  tglc_stream_if #(.T(in_item_t))  in_if ();
  tglc_stream_if #(.T(out_item_t)) out_if ();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  logic [AddrW-1:0] addr_pool [PoolSize];

  two_generation_lookup_cache #(
    .CAPACITY    (Capacity),
    .VALUE_WIDTH (ValueWidth)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tglc_result_checker #(
    .CAPACITY    (Capacity),
    .VALUE_WIDTH (ValueWidth)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_payload_i  (in_if.payload),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_payload_i (out_if.payload),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("two_generation_lookup_cache: mismatch");
      $finish;
    end
  end

  task automatic push_request(input logic kind, input logic [AddrW-1:0] addr,
                              input logic [FillW-1:0] fill);
    in_item_t item;
    item.kind       = kind;
    item.addr       = addr;
    item.fill_value = fill;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk_i); while (!in_if.ready);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic run_bursts(input int unsigned n_items, input bit sweep_first);
    int unsigned goal;
    int unsigned mode;
    int unsigned base;
    int unsigned span;
    int unsigned len;
    logic [AddrW-1:0] addr;
    goal = sent_count + n_items;
    while (sent_count < goal) begin
      mode = sweep_first ? 2 : $urandom_range(0, 2);
      sweep_first = 1'b0;
      case (mode)
        0: begin
          base = $urandom_range(0, 111);
          span = $urandom_range(4, 16);
          len  = $urandom_range(10, 40);
        end
        1: begin
          base = $urandom_range(0, 80);
          span = $urandom_range(40, 48);
          len  = $urandom_range(30, 80);
        end
        default: begin
          base = $urandom_range(0, 40);
          span = $urandom_range(66, 88);
          len  = span;
        end
      endcase
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 31) == 0) begin
          push_request(KIND_EVICT, {$urandom, $urandom}, $urandom);
        end else begin
          if ($urandom_range(0, 15) == 0) addr = {$urandom, $urandom};
          else if (mode == 2) addr = addr_pool[base + k];
          else addr = addr_pool[base + $urandom_range(0, span - 1)];
          push_request(KIND_LOOKUP, addr, $urandom);
        end
      end
      if ($urandom_range(0, 9) < 4) push_request(KIND_EVICT, {$urandom, $urandom}, $urandom);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    sent_count  = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) addr_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme keys and values, hits in both generations, evict counts
    push_request(KIND_LOOKUP, '0, '0);
    push_request(KIND_LOOKUP, '1, '1);
    push_request(KIND_LOOKUP, '0, '1);
    push_request(KIND_LOOKUP, '1, '0);
    push_request(KIND_EVICT, '1, '1);
    push_request(KIND_LOOKUP, '0, 32'h1234_5678);
    push_request(KIND_EVICT, '0, '0);
    push_request(KIND_LOOKUP, '1, 32'h5a5a_a5a5);
    push_request(KIND_LOOKUP, '0, 32'hdead_beef);
    push_request(KIND_LOOKUP, 64'h8000_0000_0000_0000, 32'h8000_0000);
    push_request(KIND_LOOKUP, 64'h0000_0000_0000_0001, 32'h0000_0001);
    push_request(KIND_EVICT, '1, '1);
    push_request(KIND_EVICT, '1, '1);
    push_request(KIND_EVICT, '0, '0);
    push_request(KIND_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);
    wait_drained();

    tx_idle_pct = 31;
    rx_idle_pct <= 82;
    run_bursts(650, 1'b1);
    wait_drained();

    tx_idle_pct = 82;
    rx_idle_pct <= 31;
    run_bursts(650, 1'b0);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_bursts(650, 1'b1);
    wait_drained();
    repeat (Capacity + 8) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("two_generation_lookup_cache: match");
    end else begin
      $display("two_generation_lookup_cache: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tglc_pkg.sv
rtl/tglc_stream_if.sv
rtl/two_generation_lookup_cache.sv
verif/tglc_result_checker.sv
verif/tb_two_generation_lookup_cache.sv
